@@ rtl/psrs_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// psrs_pkg
// Shared types and constants for the parity stopping record scan block.
// ----------------------------------------------------------------------------
package psrs_pkg;

   localparam int NUM_W   = 64;
   localparam int VAL_W   = 128;
   localparam int ADDR_W  = 12;
   localparam int DEPTH   = 4096;
   localparam int OUT_W   = 3;
   localparam int FRAC_W  = 40;

   // log(2)/log(3) as a 40-bit binary fraction; a carry out of the
   // accumulator marks each step at which floor(L*log2/log3) goes up.
   localparam logic [FRAC_W-1:0] LOG_RATIO_FRAC = 40'hA1_849C_C1AA;

   typedef enum logic [OUT_W-1:0] {
      OUT_DECIDED   = 3'd0,
      OUT_OVERFLOW  = 3'd1,
      OUT_UNDECIDED = 3'd2,
      OUT_REJECTED  = 3'd3,
      OUT_READ      = 3'd4
   } outcome_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT,
      ST_READ_OUT
   } state_type;

   typedef struct packed {
      logic clear;
      logic load;
      logic step;
      logic commit_scan;
      logic commit_read;
      logic commit_reject;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic stop;
      logic req_read;
      logic req_low;
   } stat_type;

endpackage
`default_nettype wire

@@ rtl/psrs_store.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// psrs_store
// Record memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module psrs_store (
   input  wire logic                         clock,
   input  wire logic                         wr_en,
   input  wire logic [psrs_pkg::ADDR_W-1:0]  wr_addr,
   input  wire logic [psrs_pkg::NUM_W-1:0]   wr_data,
   input  wire logic [psrs_pkg::ADDR_W-1:0]  rd_addr,
   output logic      [psrs_pkg::NUM_W-1:0]   rd_data
);
   import psrs_pkg::*;

   logic [NUM_W-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

@@ rtl/psrs_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// psrs_dp
// Datapath: parity-map iteration, stopping threshold, record update,
// outcome counters and result registers.
// ----------------------------------------------------------------------------
module psrs_dp #(
   parameter int STEP_LIMIT  = 4096,
   parameter int GUARD_SHIFT = 120
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire psrs_pkg::cmd_type             cmd,
   output psrs_pkg::stat_type                 stat,
   input  wire logic                          req_mode,
   input  wire logic [psrs_pkg::NUM_W-1:0]    req_number,
   input  wire logic [psrs_pkg::ADDR_W-1:0]   req_record_index,
   output logic                               rsp_strobe,
   output logic      [psrs_pkg::OUT_W-1:0]    rsp_outcome,
   output logic      [psrs_pkg::ADDR_W-1:0]   rsp_chi,
   output logic                               rsp_new_record,
   output logic      [psrs_pkg::NUM_W-1:0]    rsp_record_value,
   output logic      [psrs_pkg::NUM_W-1:0]    rsp_overflow_total,
   output logic      [psrs_pkg::NUM_W-1:0]    rsp_undecided_total
);
   import psrs_pkg::*;

   localparam int SW   = $clog2(STEP_LIMIT);
   localparam int WIDE = (SW > ADDR_W) ? SW : ADDR_W;
   localparam logic [SW-1:0] LAST_STEP = SW'(STEP_LIMIT - 1);

   logic [VAL_W-1:0]  v_ff;
   logic [SW-1:0]     k_ff, m_ff, step_ff;
   logic [FRAC_W-1:0] frac_ff;
   logic [NUM_W-1:0]  num_ff;
   outcome_type       outcome_ff;
   logic [ADDR_W-1:0] clr_addr_ff;
   logic [NUM_W-1:0]  ovf_cnt_ff, und_cnt_ff;

   logic              rsp_strobe_ff;
   outcome_type       rsp_outcome_ff;
   logic [ADDR_W-1:0] rsp_chi_ff;
   logic              rsp_new_ff;
   logic [NUM_W-1:0]  rsp_rec_ff;

   logic [VAL_W-1:0]  v_half, v_odd, v_in;
   logic              odd;
   logic [SW-1:0]     k_in, m_in;
   logic [FRAC_W:0]   frac_sum;
   logic              decided, overflow, last, stop;
   logic [WIDE-1:0]   step_wide;
   logic [ADDR_W-1:0] chi;
   logic              in_range;

   logic              mem_wr_en;
   logic [ADDR_W-1:0] mem_wr_addr, mem_rd_addr;
   logic [NUM_W-1:0]  mem_wr_data, mem_rd_data;
   logic              better;

   // One step of the halved 3x+1 map: odd v becomes v + v/2 + 1
   always_comb begin
      odd      = v_ff[0];
      v_half   = v_ff >> 1;
      v_odd    = v_ff + v_half + {{(VAL_W-1){1'b0}}, 1'b1};
      v_in     = odd ? v_odd : v_half;
      k_in     = k_ff + {{(SW-1){1'b0}}, odd};
      frac_sum = {1'b0, frac_ff} + {1'b0, LOG_RATIO_FRAC};
      m_in     = m_ff + {{(SW-1){1'b0}}, frac_sum[FRAC_W]};
      decided  = (k_in <= m_in);
      overflow = (v_in[VAL_W-1:GUARD_SHIFT] != '0);
      last     = (step_ff == LAST_STEP);
      stop     = decided || overflow || last;
   end

   always_comb begin
      step_wide = WIDE'(step_ff);
      chi       = step_wide[ADDR_W-1:0];
      in_range  = ((step_wide >> ADDR_W) == '0);
   end

   always_comb begin
      stat.clear_last = (clr_addr_ff == {ADDR_W{1'b1}});
      stat.stop       = stop;
      stat.req_read   = req_mode;
      stat.req_low    = (req_number[NUM_W-1:1] == '0);
   end

   // Record store: sweep to zero after reset, read chi while stepping, write a record at commit
   always_comb begin
      better = (mem_rd_data == '0) || (num_ff < mem_rd_data);
      if (cmd.clear) begin
         mem_rd_addr = clr_addr_ff;
      end else if (cmd.step) begin
         mem_rd_addr = chi;
      end else begin
         mem_rd_addr = req_record_index;
      end
      if (cmd.clear) begin
         mem_wr_en   = 1'b1;
         mem_wr_addr = clr_addr_ff;
         mem_wr_data = '0;
      end else begin
         mem_wr_en   = cmd.commit_scan && (outcome_ff == OUT_DECIDED) && in_range && better;
         mem_wr_addr = chi;
         mem_wr_data = num_ff;
      end
   end

   psrs_store u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // Scan registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         v_ff    <= {{(VAL_W-NUM_W){1'b0}}, req_number};
         num_ff  <= req_number;
         k_ff    <= '0;
         m_ff    <= '0;
         frac_ff <= '0;
         step_ff <= {{(SW-1){1'b0}}, 1'b1};
      end else if (cmd.step) begin
         v_ff    <= v_in;
         k_ff    <= k_in;
         m_ff    <= m_in;
         frac_ff <= frac_sum[FRAC_W-1:0];
         // hold the step count on the stopping step: it becomes chi
         if (!stop) begin
            step_ff <= step_ff + {{(SW-1){1'b0}}, 1'b1};
         end
         if (decided) begin
            outcome_ff <= OUT_DECIDED;
         end else if (overflow) begin
            outcome_ff <= OUT_OVERFLOW;
         end else begin
            outcome_ff <= OUT_UNDECIDED;
         end
      end
   end

   // Control state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff   <= '0;
         ovf_cnt_ff    <= '0;
         und_cnt_ff    <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         if (cmd.clear) begin
            clr_addr_ff <= clr_addr_ff + {{(ADDR_W-1){1'b0}}, 1'b1};
         end
         if (cmd.commit_scan && (outcome_ff == OUT_OVERFLOW)) begin
            ovf_cnt_ff <= ovf_cnt_ff + {{(NUM_W-1){1'b0}}, 1'b1};
         end
         if (cmd.commit_scan && (outcome_ff == OUT_UNDECIDED)) begin
            und_cnt_ff <= und_cnt_ff + {{(NUM_W-1){1'b0}}, 1'b1};
         end
         rsp_strobe_ff <= cmd.commit_scan || cmd.commit_read || cmd.commit_reject;
      end
   end

   // Result registers
   always_ff @(posedge clock) begin
      if (cmd.commit_scan) begin
         rsp_outcome_ff <= outcome_ff;
         rsp_chi_ff     <= (outcome_ff == OUT_DECIDED) ? chi : '0;
         rsp_new_ff     <= (outcome_ff == OUT_DECIDED) && in_range && better;
         rsp_rec_ff     <= '0;
      end else if (cmd.commit_read) begin
         rsp_outcome_ff <= OUT_READ;
         rsp_chi_ff     <= '0;
         rsp_new_ff     <= 1'b0;
         rsp_rec_ff     <= mem_rd_data;
      end else if (cmd.commit_reject) begin
         rsp_outcome_ff <= OUT_REJECTED;
         rsp_chi_ff     <= '0;
         rsp_new_ff     <= 1'b0;
         rsp_rec_ff     <= '0;
      end
   end

   assign rsp_strobe          = rsp_strobe_ff;
   assign rsp_outcome         = rsp_outcome_ff;
   assign rsp_chi             = rsp_chi_ff;
   assign rsp_new_record      = rsp_new_ff;
   assign rsp_record_value    = rsp_rec_ff;
   assign rsp_overflow_total  = ovf_cnt_ff;
   assign rsp_undecided_total = und_cnt_ff;

   a_odd_count_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> (k_ff < step_ff))
      else $error("odd count reached the step count");

   a_undecided_margin: assert property (@(posedge clock) disable iff (reset)
      (cmd.step && (step_ff != {{(SW-1){1'b0}}, 1'b1})) |-> (k_ff > m_ff))
      else $error("scan continued past its stopping step");

   a_value_guard: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> (v_ff[VAL_W-1:GUARD_SHIFT] == '0))
      else $error("value above guard while scanning");

   a_record_decided: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_new_ff) |-> (rsp_outcome_ff == OUT_DECIDED))
      else $error("new record on a transaction that was not decided");

endmodule
`default_nettype wire

@@ rtl/psrs_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// psrs_ctrl
// Controller: clearing pass, command acceptance, scan sequencing, commit.
// ----------------------------------------------------------------------------
module psrs_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire psrs_pkg::stat_type  stat,
   output psrs_pkg::cmd_type        cmd
);
   import psrs_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (stat.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               if (stat.req_read) begin
                  state_in = ST_READ_OUT;
               end else if (!stat.req_low) begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (stat.stop) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT:   state_in = ST_IDLE;
         ST_READ_OUT: state_in = ST_IDLE;
         default:     state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
         end
         ST_IDLE: begin
            busy              = 1'b0;
            // a number below two is answered straight from the accept edge
            cmd.load          = start && !stat.req_read && !stat.req_low;
            cmd.commit_reject = start && !stat.req_read && stat.req_low;
         end
         ST_SCAN: begin
            cmd.step = 1'b1;
         end
         ST_COMMIT: begin
            cmd.commit_scan = 1'b1;
         end
         ST_READ_OUT: begin
            cmd.commit_read = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   a_commit_returns: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COMMIT) |=> (state_ff == ST_IDLE))
      else $error("commit did not return to idle");

   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.load || cmd.commit_reject) |=> (state_ff == ST_SCAN || state_ff == ST_IDLE))
      else $error("accepted transaction led to an unexpected state");

endmodule
`default_nettype wire

@@ rtl/parity_stopping_record_scan_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// parity_stopping_record_scan_core
// Stopping-record scan of the halved 3x+1 parity map with a record store.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive req_mode, req_number and req_record_index and
//   raise start; the transaction is taken at a clock edge where busy is low.
//   Scan (req_mode 0) iterates one parity step per cycle from step 1 until
//   the odd count falls below ceil(L*log2/log3), the value reaches
//   2^GUARD_SHIFT, or step STEP_LIMIT-1 passes; a decided scan then writes
//   its number as the record for chi in the commit state if that record
//   is empty or larger. rsp_strobe is registered after the commit state
//   for a scan, after the read-out state for a read, and from the accept
//   cycle for a number below two. The next command is taken at the edge
//   that ends the result cycle, so no new command enters while a scan runs.
//   Result channel: rsp_strobe is high for exactly one cycle with the
//   result; the receiver cannot stall it. Totals stay valid until the next
//   transaction commits.
//   Reset: synchronous; busy stays high for a clearing pass over the
//   record memory, counters restart at zero.
// ----------------------------------------------------------------------------
module parity_stopping_record_scan_core #(
   parameter int STEP_LIMIT  = 4096,
   parameter int GUARD_SHIFT = 120
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic                          req_mode,
   input  wire logic [psrs_pkg::NUM_W-1:0]    req_number,
   input  wire logic [psrs_pkg::ADDR_W-1:0]   req_record_index,
   output logic                               rsp_strobe,
   output logic      [psrs_pkg::OUT_W-1:0]    rsp_outcome,
   output logic      [psrs_pkg::ADDR_W-1:0]   rsp_chi,
   output logic                               rsp_new_record,
   output logic      [psrs_pkg::NUM_W-1:0]    rsp_record_value,
   output logic      [psrs_pkg::NUM_W-1:0]    rsp_overflow_total,
   output logic      [psrs_pkg::NUM_W-1:0]    rsp_undecided_total
);
   import psrs_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   psrs_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   psrs_dp #(
      .STEP_LIMIT  (STEP_LIMIT),
      .GUARD_SHIFT (GUARD_SHIFT)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_mode            (req_mode),
      .req_number          (req_number),
      .req_record_index    (req_record_index),
      .rsp_strobe          (rsp_strobe),
      .rsp_outcome         (rsp_outcome),
      .rsp_chi             (rsp_chi),
      .rsp_new_record      (rsp_new_record),
      .rsp_record_value    (rsp_record_value),
      .rsp_overflow_total  (rsp_overflow_total),
      .rsp_undecided_total (rsp_undecided_total)
   );

endmodule
`default_nettype wire

@@ sim/parity_stopping_record_scan_core_test.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// parity_stopping_record_scan_core_test
// Self-checking bench for the parity stopping record scan core.
// Commands go in through the start/busy port in bursts with random gaps. A
// behavioral copy of the halved 3x+1 walk, the record store and both abort
// counters predicts each response. Every strobed response is checked field
// by field against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module parity_stopping_record_scan_core_test;
   import psrs_pkg::*;

   localparam int          WALK_LIMIT   = 4096;
   localparam int          GUARD_BIT    = 120;
   localparam int          RANDOM_ITEMS = 1000;
   localparam logic [63:0] RATIO_UNIT   = 64'h2000_0000_0000_0000;
   localparam logic [63:0] RATIO_THREE  = 64'h6000_0000_0000_0000;
   localparam logic [63:0] PATH_RECORD  = 64'd1980976057694848447;

   typedef struct {
      outcome_type      outcome;
      logic [ADDR_W-1:0] chi;
      logic             new_record;
      logic [NUM_W-1:0] record_value;
      logic [NUM_W-1:0] overflow_total;
      logic [NUM_W-1:0] undecided_total;
   } walk_response_type;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic              req_mode;
   logic [NUM_W-1:0]  req_number;
   logic [ADDR_W-1:0] req_record_index;
   logic              rsp_strobe;
   logic [OUT_W-1:0]  rsp_outcome;
   logic [ADDR_W-1:0] rsp_chi;
   logic              rsp_new_record;
   logic [NUM_W-1:0]  rsp_record_value;
   logic [NUM_W-1:0]  rsp_overflow_total;
   logic [NUM_W-1:0]  rsp_undecided_total;

   // predictor state
   logic [NUM_W-1:0]  least_by_step [DEPTH];
   logic [NUM_W-1:0]  overflow_seen;
   logic [NUM_W-1:0]  undecided_seen;
   logic [ADDR_W-1:0] recorded_steps [$];
   walk_response_type pending_responses [$];
   int                mismatch_count;

   parity_stopping_record_scan_core dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_mode            (req_mode),
      .req_number          (req_number),
      .req_record_index    (req_record_index),
      .rsp_strobe          (rsp_strobe),
      .rsp_outcome         (rsp_outcome),
      .rsp_chi             (rsp_chi),
      .rsp_new_record      (rsp_new_record),
      .rsp_record_value    (rsp_record_value),
      .rsp_overflow_total  (rsp_overflow_total),
      .rsp_undecided_total (rsp_undecided_total)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #250_000_000;
      $display("== FAIL ==");
      $finish;
   end

   task automatic flag_mismatch(input string what, input logic [63:0] got,
                                input logic [63:0] want);
      $display("mismatch %s: got %0h, want %0h at %0t", what, got, want, $time);
      mismatch_count++;
   endtask

   // Walk the halved parity map; floor(L*log2/log3) follows 2^L/3^m in Q3.61.
   function automatic outcome_type walk_parity(input logic [63:0] number,
                                               output logic [ADDR_W-1:0] stop_at);
      logic [127:0] value;
      logic [63:0]  ratio;
      logic [31:0]  walk_step;
      int           odd_steps;
      int           floor_m;
      value     = {64'd0, number};
      ratio     = RATIO_UNIT;
      odd_steps = 0;
      floor_m   = 0;
      stop_at   = '0;
      for (walk_step = 1; walk_step < WALK_LIMIT; walk_step++) begin
         if (value[0]) begin
            value = value + (value >> 1) + 128'd1;
            odd_steps++;
         end else begin
            value = value >> 1;
         end
         ratio = ratio << 1;
         if (ratio >= RATIO_THREE) begin
            ratio = ratio / 3;
            floor_m++;
         end
         if (odd_steps <= floor_m) begin
            stop_at = walk_step[ADDR_W-1:0];
            return OUT_DECIDED;
         end
         if (value[127:GUARD_BIT] != '0) return OUT_OVERFLOW;
      end
      return OUT_UNDECIDED;
   endfunction

   task automatic predict_response(input logic mode, input logic [63:0] number,
                                   input logic [ADDR_W-1:0] index);
      walk_response_type resp;
      logic [ADDR_W-1:0] stop_at;
      resp.outcome      = OUT_READ;
      resp.chi          = '0;
      resp.new_record   = 1'b0;
      resp.record_value = '0;
      if (mode) begin
         resp.record_value = least_by_step[index];
      end else if (number < 64'd2) begin
         resp.outcome = OUT_REJECTED;
      end else begin
         resp.outcome = walk_parity(number, stop_at);
         case (resp.outcome)
            OUT_DECIDED: begin
               resp.chi = stop_at;
               if (least_by_step[stop_at] == '0 || number < least_by_step[stop_at]) begin
                  if (least_by_step[stop_at] == '0) recorded_steps.push_back(stop_at);
                  least_by_step[stop_at] = number;
                  resp.new_record        = 1'b1;
               end
            end
            OUT_OVERFLOW: overflow_seen++;
            default:      undecided_seen++;
         endcase
      end
      resp.overflow_total  = overflow_seen;
      resp.undecided_total = undecided_seen;
      pending_responses.push_back(resp);
   endtask

   // Drive at the falling edge and hold start until an edge with busy low.
   task automatic send_command(input logic mode, input logic [63:0] number,
                               input logic [ADDR_W-1:0] index);
      @(negedge clock);
      start            = 1'b1;
      req_mode         = mode;
      req_number       = number;
      req_record_index = index;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      predict_response(mode, number, index);
   endtask

   task automatic pause_sender(input int cycles);
      @(negedge clock);
      start = 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic wait_for_drain();
      @(negedge clock);
      start = 1'b0;
      while (pending_responses.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      walk_response_type want;
      if (reset === 1'b0 && rsp_strobe === 1'b1) begin
         if (pending_responses.size() == 0) begin
            flag_mismatch("unexpected transaction, outcome", 64'(rsp_outcome), '0);
         end else begin
            want = pending_responses.pop_front();
            if (rsp_outcome !== want.outcome)
               flag_mismatch("outcome", 64'(rsp_outcome), 64'(want.outcome));
            if (rsp_chi !== want.chi)
               flag_mismatch("chi", 64'(rsp_chi), 64'(want.chi));
            if (rsp_new_record !== want.new_record)
               flag_mismatch("new_record", 64'(rsp_new_record), 64'(want.new_record));
            if (rsp_record_value !== want.record_value)
               flag_mismatch("record_value", rsp_record_value, want.record_value);
            if (rsp_overflow_total !== want.overflow_total)
               flag_mismatch("overflow_total", rsp_overflow_total, want.overflow_total);
            if (rsp_undecided_total !== want.undecided_total)
               flag_mismatch("undecided_total", rsp_undecided_total, want.undecided_total);
         end
      end
   end

   task automatic test_cleared_store();
      send_command(1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 12'd0);
      send_command(1'b1, 64'd0, 12'hFFF);
   endtask

   task automatic test_below_two();
      send_command(1'b0, 64'd0, 12'hFFF);
      send_command(1'b0, 64'd1, 12'd0);
   endtask

   // Only a strictly smaller number takes over a record.
   task automatic test_record_order();
      send_command(1'b0, 64'd100, 12'd0);
      send_command(1'b0, 64'd4, 12'd0);
      pause_sender(3);
      send_command(1'b0, 64'd4, 12'd0);
      send_command(1'b0, 64'd2, 12'd0);
      send_command(1'b0, 64'd7, 12'd0);
      send_command(1'b0, 64'd3, 12'd0);
      send_command(1'b0, 64'd27, 12'd0);
   endtask

   task automatic test_wide_numbers();
      send_command(1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 12'd0);
      send_command(1'b0, 64'h8000_0000_0000_0000, 12'd0);
      send_command(1'b0, 64'h8000_0000_0000_0001, 12'd0);
      // long climb that should cross the guard bit
      send_command(1'b0, PATH_RECORD, 12'd0);
      send_command(1'b0, 64'h7FFF_FFFF_FFFF_FFFF, 12'd0);
   endtask

   task automatic test_record_reads();
      send_command(1'b1, 64'd0, 12'd1);
      send_command(1'b1, 64'd0, 12'd4);
      send_command(1'b1, 64'd0, recorded_steps[recorded_steps.size() - 1]);
   endtask

   task automatic test_drain_pause();
      send_command(1'b0, 64'd9, 12'd0);
      send_command(1'b0, 64'd11, 12'd0);
      wait_for_drain();
      send_command(1'b1, 64'd0, 12'd1);
   endtask

   task automatic send_random_command();
      logic [63:0]       number;
      logic [ADDR_W-1:0] index;
      int                pick;
      number = {$urandom, $urandom};
      index  = ADDR_W'($urandom_range(0, DEPTH - 1));
      pick   = $urandom_range(0, 99);
      if (pick < 20) begin
         if (pick < 10) index = ADDR_W'($urandom_range(0, 127));
         else if (pick < 15 && recorded_steps.size() != 0)
            index = recorded_steps[$urandom_range(0, recorded_steps.size() - 1)];
         send_command(1'b1, number, index);
      end else if (pick < 23) begin
         send_command(1'b0, {63'd0, number[0]}, index);
      end else if (pick < 58) begin
         send_command(1'b0, 64'($urandom_range(2, 65535)), index);
      end else if (pick < 70) begin
         // long run of low ones gives a long climb
         send_command(1'b0, number | ((64'd1 << $urandom_range(1, 63)) - 64'd1), index);
      end else begin
         send_command(1'b0, number, index);
      end
   endtask

   task automatic test_random_traffic();
      int sent;
      int burst;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         burst = $urandom_range(0, 7) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 12);
         repeat (burst) begin
            send_random_command();
            sent++;
         end
         if ($urandom_range(0, 49) == 0) wait_for_drain();
         else if ($urandom_range(0, 3) != 0) pause_sender($urandom_range(1, 12));
      end
   endtask

   initial begin
      reset            = 1'b1;
      start            = 1'b0;
      req_mode         = 1'b0;
      req_number       = '0;
      req_record_index = '0;
      overflow_seen    = '0;
      undecided_seen   = '0;
      mismatch_count   = 0;
      for (int i = 0; i < DEPTH; i++) least_by_step[ADDR_W'(i)] = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_cleared_store();
      test_below_two();
      test_record_order();
      test_wide_numbers();
      test_record_reads();
      test_drain_pause();
      test_random_traffic();

      wait_for_drain();
      repeat (16) @(posedge clock);
      if (pending_responses.size() != 0)
         flag_mismatch("missing transactions", 64'(pending_responses.size()), 64'd0);
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
`default_nettype wire

@@ parity_stopping_record_scan_core.f @@
rtl/psrs_pkg.sv
rtl/psrs_store.sv
rtl/psrs_dp.sv
rtl/psrs_ctrl.sv
rtl/parity_stopping_record_scan_core.sv
sim/parity_stopping_record_scan_core_test.sv
